### rtl/lbpm_pkg.sv
// shared types and constants of the led bar power meter
`default_nettype none

package lbpm_pkg;

  localparam int MAG_W    = 16;
  localparam int LEVEL_W  = 8;
  localparam int CFG_IX_W = 3;
  localparam int CFG_D_W  = 16;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_ANIM   = 2'd1;
  localparam logic [1:0] OP_LEVEL  = 2'd2;

  localparam logic [CFG_IX_W-1:0] CFG_FS_CONS = 3'd0;
  localparam logic [CFG_IX_W-1:0] CFG_FS_PROD = 3'd1;
  localparam logic [CFG_IX_W-1:0] CFG_BR_CONS = 3'd2;
  localparam logic [CFG_IX_W-1:0] CFG_BR_PROD = 3'd3;
  localparam logic [CFG_IX_W-1:0] CFG_SLEW    = 3'd4;

  localparam logic [MAG_W-1:0]   FS_RESET   = 16'd5000;
  localparam logic [LEVEL_W-1:0] BR_RESET   = 8'd64;
  localparam logic [LEVEL_W-1:0] SLEW_RESET = 8'd4;
  localparam logic [MAG_W-1:0]   MAG_MAX    = 16'hFFFF;

  typedef struct packed {
    logic [1:0]       op;
    logic             producing;
    logic [MAG_W-1:0] magnitude;
  } lbpm_job_t;

  typedef struct packed {
    logic [MAG_W-1:0]   fs_cons;
    logic [MAG_W-1:0]   fs_prod;
    logic [LEVEL_W-1:0] br_cons;
    logic [LEVEL_W-1:0] br_prod;
    logic [LEVEL_W-1:0] slew_step;
  } lbpm_cfg_t;

endpackage

`default_nettype wire

### rtl/lbpm_front.sv
// front end: accepts input words, drops unused commands, forms jobs
`default_nettype none

module lbpm_front
  import lbpm_pkg::*;
(
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [1:0]        command,
  input  wire logic signed [16:0] power_sample,
  input  wire logic              queue_full,
  output logic                   push,
  output lbpm_job_t              job
);

  logic [16:0] neg;

  assign in_stall = queue_full;
  assign neg      = ~power_sample + 17'd1;

  always_comb begin
    job.op        = command;
    job.producing = power_sample[16];
    if (!power_sample[16]) begin
      job.magnitude = power_sample[15:0];
    end else if (neg[16]) begin
      job.magnitude = MAG_MAX;
    end else begin
      job.magnitude = neg[15:0];
    end
    push = in_valid && !queue_full &&
           (command == OP_SAMPLE || command == OP_ANIM || command == OP_LEVEL);
  end

endmodule

`default_nettype wire

### rtl/lbpm_queue.sv
// two-entry job queue between front and back
`default_nettype none

module lbpm_queue
  import lbpm_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push,
  input  wire lbpm_job_t push_job,
  output logic           full,
  input  wire logic      pop,
  output lbpm_job_t      pop_job,
  output logic           empty
);

  lbpm_job_t   slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign pop_job = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/lbpm_back.sv
// back end: level divider, brightness slew lanes and pixel output register
`default_nettype none

module lbpm_back
  import lbpm_pkg::*;
#(
  parameter int LED_TOTAL = 16
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire lbpm_cfg_t cfg,
  input  wire lbpm_job_t job,
  input  wire logic      job_ready,
  output logic           pop,
  output logic           out_valid,
  input  wire logic      out_stall,
  output logic [5:0]     led_index,
  output logic [7:0]     red_level,
  output logic [7:0]     green_level,
  output logic           last_pixel
);

  localparam int LIT_W  = $clog2(LED_TOTAL + 1);
  localparam int IDX_W  = (LED_TOTAL > 1) ? $clog2(LED_TOTAL) : 1;
  localparam int DIV_SH = MAG_W + $clog2(LED_TOTAL);
  localparam int PROD_W = 2 * MAG_W + 1;
  localparam logic [MAG_W:0] RECIP =
    (MAG_W+1)'(((64'd1 << DIV_SH) + 64'(LED_TOTAL) - 64'd1) / 64'(LED_TOTAL));

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GOAL = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]         state;
  logic               producing;
  logic [MAG_W-1:0]   magnitude;
  logic [LIT_W-1:0]   lit;
  logic [LEVEL_W-1:0] tgt_bright;
  logic [LEVEL_W-1:0] shown [LED_TOTAL];
  logic [LEVEL_W-1:0] slewed [LED_TOTAL];
  logic               changed;

  logic [MAG_W-1:0]   quo;
  logic [MAG_W-1:0]   p_lim;
  logic [LEVEL_W-1:0] bright_l;
  logic [MAG_W-1:0]   acc;
  logic [LIT_W-1:0]   k;
  logic [LIT_W-1:0]   goal;
  logic [IDX_W-1:0]   idx;

  logic [MAG_W-1:0]   fs_cur;
  logic [PROD_W-1:0]  quo_prod;
  logic [PROD_W-1:0]  quo_shift;
  logic [MAG_W-1:0]   quo_calc;
  logic [MAG_W:0]     acc_sum;
  logic               hit;
  logic [LIT_W-1:0]   goal_now;
  logic [LIT_W-1:0]   goal_fin;
  logic [LIT_W-1:0]   lit_next;
  logic               load;
  logic               idx_last;

  // one slew lane per led, target follows from lit count
  always_comb begin
    logic [LEVEL_W-1:0] t;
    logic [LEVEL_W-1:0] s;
    changed = 1'b0;
    for (int i = 0; i < LED_TOTAL; i++) begin
      t = (LIT_W'(i) < lit) ? tgt_bright : '0;
      s = shown[i];
      if (s < t) begin
        slewed[i] = ((t - s) > cfg.slew_step) ? s + cfg.slew_step : t;
        changed   = 1'b1;
      end else if (s > t) begin
        slewed[i] = ((s - t) > cfg.slew_step) ? s - cfg.slew_step : t;
        changed   = 1'b1;
      end else begin
        slewed[i] = s;
      end
    end
  end

  always_comb begin
    fs_cur    = producing ? cfg.fs_prod : cfg.fs_cons;
    quo_prod  = {{(MAG_W+1){1'b0}}, fs_cur} * {{MAG_W{1'b0}}, RECIP};
    quo_shift = quo_prod >> DIV_SH;
    quo_calc  = quo_shift[MAG_W-1:0];
    acc_sum   = {1'b0, acc} + {1'b0, quo};
    hit       = (acc_sum <= {1'b0, p_lim});
    goal_now  = hit ? k + LIT_W'(1) : goal;
    goal_fin  = (quo == '0) ? LIT_W'(LED_TOTAL) : goal_now;
    if (goal_fin > lit) begin
      lit_next = lit + LIT_W'(1);
    end else if (goal_fin < lit) begin
      lit_next = lit - LIT_W'(1);
    end else begin
      lit_next = lit;
    end
    pop      = (state == ST_IDLE) && job_ready;
    load     = (state == ST_EMIT) && (!out_valid || !out_stall);
    idx_last = (idx == IDX_W'(LED_TOTAL - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      producing  <= 1'b0;
      magnitude  <= '0;
      lit        <= '0;
      tgt_bright <= '0;
      out_valid  <= 1'b0;
      for (int i = 0; i < LED_TOTAL; i++) begin
        shown[i] <= '0;
      end
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (pop) begin
            unique case (job.op)
              OP_SAMPLE: begin
                producing <= job.producing;
                magnitude <= job.magnitude;
              end
              OP_ANIM: begin
                for (int i = 0; i < LED_TOTAL; i++) begin
                  shown[i] <= slewed[i];
                end
                idx <= '0;
                if (changed) begin
                  state <= ST_EMIT;
                end
              end
              OP_LEVEL: begin
                quo      <= quo_calc;
                p_lim    <= (magnitude > fs_cur) ? fs_cur : magnitude;
                bright_l <= producing ? cfg.br_prod : cfg.br_cons;
                acc      <= '0;
                k        <= '0;
                goal     <= '0;
                state    <= ST_GOAL;
              end
              default: begin
              end
            endcase
          end
        end
        ST_GOAL: begin
          acc  <= acc_sum[MAG_W-1:0];
          k    <= k + LIT_W'(1);
          goal <= goal_now;
          if (k == LIT_W'(LED_TOTAL - 1)) begin
            lit        <= lit_next;
            tgt_bright <= bright_l;
            state      <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (load) begin
            led_index   <= 6'(idx);
            red_level   <= producing ? '0 : shown[0];
            green_level <= producing ? shown[0] : '0;
            last_pixel  <= idx_last;
            for (int i = 0; i < LED_TOTAL - 1; i++) begin
              shown[i] <= shown[i+1];
            end
            shown[LED_TOTAL-1] <= shown[0];
            idx <= idx + IDX_W'(1);
            if (idx_last) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/led_bar_power_meter.sv
// top level of the led bar power meter: configuration registers and job path
//
// input channel: in_valid, in_stall, command, power_sample; a word is taken
// when in_valid is high and in_stall low. command 0 stores a power sample,
// 1 is an animation tick, 2 a level update tick, 3 is taken and ignored.
// output channel: out_valid, out_stall and one pixel word per led
// (led_index, red_level, green_level, last_pixel); a frame is LED_TOTAL
// words, last_pixel marks the final one.
// configuration: cfg_valid, cfg_ready, cfg_index, cfg_data; cfg_ready is
// always high, writes are meant for idle periods only.
// flow: a two-entry queue sits between the front and the back, so input
// words are taken while the back works. a sample is stored by an idle
// back, an animation tick steps the brightnesses and sends a frame of
// LED_TOTAL pixel words when any changed, a level tick runs the goal count
// pass over all leds; the first pixel word is loaded in the emit state.
// reset (rst, synchronous) clears the control state, brightnesses to zero and
// registers to their defaults. while out_stall is high the pixel word holds
// and the frame pauses; the queue then fills and in_stall rises.
`default_nettype none

module led_bar_power_meter
  import lbpm_pkg::*;
#(
  parameter int LED_TOTAL = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [1:0]          command,
  input  wire logic signed [16:0]  power_sample,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic [5:0]               led_index,
  output logic [7:0]               red_level,
  output logic [7:0]               green_level,
  output logic                     last_pixel,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CFG_IX_W-1:0] cfg_index,
  input  wire logic [CFG_D_W-1:0]  cfg_data
);

  lbpm_cfg_t cfg;
  lbpm_job_t push_job;
  lbpm_job_t pop_job;
  logic      push;
  logic      pop;
  logic      full;
  logic      empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fs_cons   <= FS_RESET;
      cfg.fs_prod   <= FS_RESET;
      cfg.br_cons   <= BR_RESET;
      cfg.br_prod   <= BR_RESET;
      cfg.slew_step <= SLEW_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_FS_CONS: cfg.fs_cons   <= cfg_data;
        CFG_FS_PROD: cfg.fs_prod   <= cfg_data;
        CFG_BR_CONS: cfg.br_cons   <= cfg_data[LEVEL_W-1:0];
        CFG_BR_PROD: cfg.br_prod   <= cfg_data[LEVEL_W-1:0];
        CFG_SLEW:    cfg.slew_step <= cfg_data[LEVEL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  lbpm_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .power_sample (power_sample),
    .queue_full   (full),
    .push         (push),
    .job          (push_job)
  );

  lbpm_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .pop_job  (pop_job),
    .empty    (empty)
  );

  lbpm_back #(
    .LED_TOTAL (LED_TOTAL)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .job         (pop_job),
    .job_ready   (!empty),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .led_index   (led_index),
    .red_level   (red_level),
    .green_level (green_level),
    .last_pixel  (last_pixel)
  );

endmodule

`default_nettype wire

### tb/led_bar_power_meter_test.sv
// self-checking testbench for the led bar power meter: directed table, random phases, scoreboard
`timescale 1ns / 1ps

module led_bar_power_meter_test;
  import lbpm_pkg::*;

  localparam int LEDS        = 16;
  localparam int SETTLE      = 3 * (1 + 16 + LEDS) + 20;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PLAN_LEN    = 22;
  localparam logic [1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [5:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic       last;
  } pixel_t;

  typedef struct {
    logic [1:0]  op;
    logic [16:0] raw;
    bit          fixed;
    int          count;
    logic [7:0]  first;
    logic [7:0]  rest;
    bit          green;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] command = OP_SAMPLE;
  logic signed [16:0] power_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [5:0] led_index;
  logic [7:0] red_level;
  logic [7:0] green_level;
  logic last_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IX_W-1:0] cfg_index = CFG_FS_CONS;
  logic [CFG_D_W-1:0] cfg_data = '0;

  led_bar_power_meter #(.LED_TOTAL(LEDS)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .power_sample(power_sample),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .led_index(led_index),
    .red_level(red_level),
    .green_level(green_level),
    .last_pixel(last_pixel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // meter state as the block should hold it
  lbpm_cfg_t  cfg_m;
  logic       producing_m;
  logic [15:0] mag_m;
  int         lit_m;
  logic [7:0] target_m [LEDS];
  logic [7:0] shown_m [LEDS];

  pixel_t pixels_due [$];
  plan_row_t plan [PLAN_LEN];

  int cycles = 0;
  int misses = 0;
  int pixels_checked = 0;
  int words_in = 0;
  int settings = 0;
  int burst_left = 0;
  bit calm = 1'b0;
  int stall_mode = 0;

  function automatic void meter_step(input logic [1:0] op, input logic [16:0] raw,
                                     input bit keep);
    logic [16:0] neg;
    int fs, br, p, dv, goal, s, t, step, i;
    bit moved;
    pixel_t px;
    case (op)
      OP_SAMPLE: begin
        producing_m = raw[16];
        neg = raw[16] ? -raw : raw;
        mag_m = (neg > 17'h0FFFF) ? MAG_MAX : neg[15:0];
      end
      OP_LEVEL: begin
        fs = producing_m ? cfg_m.fs_prod : cfg_m.fs_cons;
        br = producing_m ? cfg_m.br_prod : cfg_m.br_cons;
        p = (mag_m > fs) ? fs : mag_m;
        dv = fs / LEDS;
        goal = (dv == 0) ? LEDS : p / dv;
        if (goal > LEDS) goal = LEDS;
        if (goal > lit_m) lit_m++;
        else if (goal < lit_m) lit_m--;
        for (i = 0; i < LEDS; i++) target_m[i] = (i < lit_m) ? br[7:0] : 8'd0;
      end
      OP_ANIM: begin
        step = cfg_m.slew_step;
        moved = 1'b0;
        for (i = 0; i < LEDS; i++) begin
          s = shown_m[i];
          t = target_m[i];
          if (s < t) begin
            s = (t - s > step) ? s + step : t;
            moved = 1'b1;
          end else if (s > t) begin
            s = (s - t > step) ? s - step : t;
            moved = 1'b1;
          end
          shown_m[i] = s[7:0];
        end
        if (moved && keep) begin
          for (i = 0; i < LEDS; i++) begin
            px.idx = 6'(i);
            px.red = producing_m ? 8'd0 : shown_m[i];
            px.green = producing_m ? shown_m[i] : 8'd0;
            px.last = (i == LEDS - 1);
            pixels_due.push_back(px);
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send(input logic [1:0] op, input logic [16:0] raw);
    in_valid <= 1'b1;
    command <= op;
    power_sample <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_in++;
  endtask

  task automatic pace;
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 11);
      if (!calm) begin
        gap = $urandom_range(1, 15);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(input int fsc, input int fsp, input int brc, input int brp,
                           input int slew);
    logic [CFG_IX_W-1:0] ix [5];
    logic [CFG_D_W-1:0] v [5];
    int j;
    ix[0] = CFG_FS_CONS; v[0] = fsc[15:0];
    ix[1] = CFG_FS_PROD; v[1] = fsp[15:0];
    ix[2] = CFG_BR_CONS; v[2] = brc[15:0];
    ix[3] = CFG_BR_PROD; v[3] = brp[15:0];
    ix[4] = CFG_SLEW;    v[4] = slew[15:0];
    drain();
    for (j = 0; j < 5; j++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ix[j];
      cfg_data <= v[j];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (ix[j])
        CFG_FS_CONS: cfg_m.fs_cons = v[j];
        CFG_FS_PROD: cfg_m.fs_prod = v[j];
        CFG_BR_CONS: cfg_m.br_cons = v[j][7:0];
        CFG_BR_PROD: cfg_m.br_prod = v[j][7:0];
        CFG_SLEW:    cfg_m.slew_step = v[j][7:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
    settings++;
  endtask

  task automatic run_random(input int n);
    int done, r, kind, fs, hi;
    logic [1:0] op;
    logic [16:0] raw;
    done = 0;
    while (done < n) begin
      r = $urandom_range(0, 99);
      op = (r < 18) ? OP_SAMPLE : (r < 48) ? OP_LEVEL : (r < 95) ? OP_ANIM : OP_SPARE;
      raw = 17'($urandom_range(0, 17'h1FFFF));
      if (op == OP_SAMPLE) begin
        kind = $urandom_range(0, 5);
        fs = $urandom_range(0, 1) ? cfg_m.fs_prod : cfg_m.fs_cons;
        hi = (fs + fs / 8 > 65535) ? 65535 : fs + fs / 8;
        case (kind)
          0: raw = '0;
          1: raw = 17'h10000;
          2: raw = 17'($urandom_range(0, 65535));
          3: raw = 17'($urandom_range(0, hi));
          4: raw = 17'($urandom_range(0, 300));
          default: ;
        endcase
        if (kind >= 2 && kind <= 4 && $urandom_range(0, 1)) raw = -raw;
      end
      send(op, raw);
      meter_step(op, raw, 1'b1);
      pace();
      if (op != OP_SPARE) begin
        done++;
        if (done == n / 2) drain();
      end
    end
  endtask

  task automatic flag_miss(input string why, input pixel_t want, input pixel_t got);
    misses++;
    if (misses <= 10) begin
      $display("%s at cycle %0d: got led %0d red %0d green %0d last %0d, expected led %0d red %0d green %0d last %0d",
               why, cycles, got.idx, got.red, got.green, got.last,
               want.idx, want.red, want.green, want.last);
    end
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timed out with %0d pixel words outstanding", pixels_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    pixel_t got;
    if (out_valid && !out_stall) begin
      got = '{led_index, red_level, green_level, last_pixel};
      pixels_checked++;
      if (pixels_due.size() == 0) begin
        flag_miss("unexpected pixel word", got, got);
      end else begin
        want = pixels_due.pop_front();
        if (got !== want) flag_miss("pixel mismatch", want, got);
      end
    end
    if (cycles % 50 == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ((cycles % 9) < 4);
      default: out_stall <= ($urandom_range(0, 9) < 6);
    endcase
  end

  initial begin
    plan[0]  = '{OP_ANIM,   17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[1]  = '{OP_LEVEL,  17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[2]  = '{OP_ANIM,   17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[3]  = '{OP_SAMPLE, 17'h0FFFF, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[4]  = '{OP_LEVEL,  17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[5]  = '{OP_ANIM,   17'h00000, 1'b1, 16, 8'd4,  8'd0, 1'b0};
    plan[6]  = '{OP_SPARE,  17'h1FFFF, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[7]  = '{OP_ANIM,   17'h00000, 1'b1, 16, 8'd8,  8'd0, 1'b0};
    plan[8]  = '{OP_SAMPLE, 17'h10000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[9]  = '{OP_ANIM,   17'h00000, 1'b1, 16, 8'd12, 8'd0, 1'b1};
    plan[10] = '{OP_LEVEL,  17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[11] = '{OP_ANIM,   17'h00000, 1'b0, 0,  8'd0,  8'd0, 1'b0};
    plan[12] = '{OP_SAMPLE, 17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[13] = '{OP_LEVEL,  17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[14] = '{OP_ANIM,   17'h00000, 1'b0, 0,  8'd0,  8'd0, 1'b0};
    plan[15] = '{OP_SAMPLE, 17'd2500,  1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[16] = '{OP_LEVEL,  17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[17] = '{OP_LEVEL,  17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[18] = '{OP_ANIM,   17'h00000, 1'b0, 0,  8'd0,  8'd0, 1'b0};
    plan[19] = '{OP_SAMPLE, 17'h1FFFF, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[20] = '{OP_LEVEL,  17'h00000, 1'b1, 0,  8'd0,  8'd0, 1'b0};
    plan[21] = '{OP_ANIM,   17'h00000, 1'b0, 0,  8'd0,  8'd0, 1'b0};
  end

  initial begin
    int k;
    int n;
    logic [7:0] lvl;
    pixel_t px;
    cfg_m = '{FS_RESET, FS_RESET, BR_RESET, BR_RESET, SLEW_RESET};
    producing_m = 1'b0;
    mag_m = '0;
    lit_m = 0;
    for (k = 0; k < LEDS; k++) begin
      target_m[k] = '0;
      shown_m[k] = '0;
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table at reset settings
    for (k = 0; k < PLAN_LEN; k++) begin
      send(plan[k].op, plan[k].raw);
      if (plan[k].fixed) begin
        for (n = 0; n < plan[k].count; n++) begin
          lvl = (n == 0) ? plan[k].first : plan[k].rest;
          px.idx = 6'(n);
          px.red = plan[k].green ? 8'd0 : lvl;
          px.green = plan[k].green ? lvl : 8'd0;
          px.last = (n == LEDS - 1);
          pixels_due.push_back(px);
        end
        meter_step(plan[k].op, plan[k].raw, 1'b0);
      end else begin
        meter_step(plan[k].op, plan[k].raw, 1'b1);
      end
      pace();
    end

    configure(65535, 1, 255, 0, 255);
    run_random(60);
    calm = 1'b1;
    configure(15, 16, 1, 255, 1);
    run_random(60);
    calm = 1'b0;
    // zero slew: frames keep coming while any led is off target
    configure(800, 800, 200, 100, 0);
    run_random(14);
    configure($urandom_range(1, 4000), $urandom_range(1, 65535), $urandom_range(0, 255),
              $urandom_range(0, 255), $urandom_range(1, 255));
    run_random(60);
    configure(FS_RESET, FS_RESET, BR_RESET, BR_RESET, SLEW_RESET);
    run_random(60);
    drain();

    $display("%0d input words and %0d pixel words over %0d register settings",
             words_in, pixels_checked, settings);
    $display("%0d mismatches", misses);
    if (misses == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
